// ===== hw/rtl/fpds_pkg.sv =====
// shared types, sizes and codes for the dual-order request store
// no dependencies; imported by every rtl module of the block
package fpds_pkg;

    // store geometry and field widths
    localparam int CAPACITY = 256;
    localparam int ID_W     = 32;
    localparam int VALUE_W  = 20;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int BIT_W    = $clog2(VALUE_W);

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((OP_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + ID_W + 7) / 8) * 8;

    // request codes
    localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_OLDEST  = 2'd1;
    localparam logic [OP_W-1:0] OP_RICHEST = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SERVED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_LOAD,
        CELL_STEP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t            cmd;
        logic                 any_hi;
        logic [ID_W-1:0]      new_id;
        logic [VALUE_W-1:0]   new_value;
    } cell_ctl_t;

    // contents a cell hands to its lower neighbor
    typedef struct packed {
        logic                 occ;
        logic [ID_W-1:0]      id;
        logic [VALUE_W-1:0]   value;
    } cell_data_t;

endpackage

// ===== hw/rtl/fpds_cell.sv =====
// one slot of the store: id, value, occupied flag and search candidate bit
// depends on fpds_pkg
module fpds_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fpds_pkg::cell_ctl_t   ctl,
    input  logic                  prev_occ,
    input  logic                  shift_en,
    input  fpds_pkg::cell_data_t  upper,
    output fpds_pkg::cell_data_t  data,
    output logic                  cand,
    output logic                  msb
);
    import fpds_pkg::*;

    logic               occ_reg, occ_next;
    logic               cand_reg, cand_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    // per-cell command decode
    always_comb begin
        occ_next   = occ_reg;
        cand_next  = cand_reg;
        id_next    = id_reg;
        value_next = value_reg;
        unique case (ctl.cmd)
            CELL_APPEND: begin
                // the first empty slot takes the arrival
                if (!occ_reg && prev_occ) begin
                    occ_next   = 1'b1;
                    id_next    = ctl.new_id;
                    value_next = ctl.new_value;
                end
            end
            CELL_REMOVE: begin
                // slots at and above the removed one take their upper neighbor
                if (shift_en) begin
                    occ_next   = upper.occ;
                    id_next    = upper.id;
                    value_next = upper.value;
                end
            end
            CELL_LOAD: begin
                cand_next = occ_reg;
            end
            CELL_STEP: begin
                // drop out when some candidate has a one where this one has zero
                if (ctl.any_hi) begin
                    cand_next = cand_reg & value_reg[VALUE_W-1];
                end
                value_next = {value_reg[VALUE_W-2:0], value_reg[VALUE_W-1]};
            end
            default: begin
            end
        endcase
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= 1'b0;
            cand_reg <= 1'b0;
        end else begin
            occ_reg  <= occ_next;
            cand_reg <= cand_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        value_reg <= value_next;
    end

    assign data.occ   = occ_reg;
    assign data.id    = id_reg;
    assign data.value = value_reg;
    assign cand       = cand_reg;
    assign msb        = value_reg[VALUE_W-1];

endmodule

// ===== hw/rtl/fpds_pick.sv =====
// picks the lowest surviving candidate and builds the shift mask and served id
// depends on fpds_pkg
module fpds_pick (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [fpds_pkg::CAPACITY-1:0] cand_vec,
    input  logic [fpds_pkg::ID_W-1:0]   ids [fpds_pkg::CAPACITY],
    output logic [fpds_pkg::CAPACITY-1:0] sel,
    output logic [fpds_pkg::CAPACITY-1:0] shift_vec,
    output logic [fpds_pkg::ID_W-1:0]   pick_id
);
    import fpds_pkg::*;

    logic [CAPACITY-1:0] cand_dec;
    logic [CAPACITY-1:0] sel_reg, sel_next;
    logic [CAPACITY-1:0] shift_reg, shift_next;
    logic [ID_W-1:0]     id_acc;

    // lowest set bit and the mask of everything from it upward
    always_comb begin
        cand_dec   = cand_vec - CAPACITY'(1);
        sel_next   = cand_vec & ~cand_dec;
        shift_next = ~(cand_dec & ~cand_vec);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sel_reg   <= sel_next;
            shift_reg <= shift_next;
        end
    end

    // and-or select of the chosen cell's id
    always_comb begin
        id_acc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            id_acc = id_acc | (ids[i] & {ID_W{sel_reg[i]}});
        end
    end

    assign sel       = sel_reg;
    assign shift_vec = shift_reg;
    assign pick_id   = id_acc;

endmodule

// ===== hw/rtl/fifo_and_priority_dual_server.sv =====
// top level of the dual-order request store: sequencer, cell row and pick unit
// depends on fpds_pkg, fpds_cell and fpds_pick
//
//  channel | dir | fields (lsb first)                 | beat accepted when
//  s_      | in  | op[1:0], money[21:2]               | s_tvalid && s_tready
//  m_      | out | status[1:0], customer_id[33:2]     | m_tvalid && m_tready
//
// arrival, serve-oldest, empty and full requests finish in the accept cycle; the
// next beat waits until the result has left. serve-richest runs a load, 20
// bit-serial compare steps over the cell row (one value bit per cycle), a pick
// and a removal shift before its result.
// reset empties the store at once and restarts ids at 1; a stalled result holds
// the block, since s_tready is low while m_tvalid is high.
module fifo_and_priority_dual_server (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fpds_pkg::S_DATA_W-1:0] s_tdata,  // op[1:0], money[21:2], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fpds_pkg::M_DATA_W-1:0] m_tdata   // status[1:0], customer_id[33:2], zero pad
);
    import fpds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_PICK   = 4'b0100,
        S_REMOVE = 4'b1000
    } fsm_t;

    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [BIT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [ID_W-1:0]    m_id_reg, m_id_next;

    logic [OP_W-1:0]    in_op;
    logic [VALUE_W-1:0] in_money;
    logic               s_fire;
    logic               out_set;

    cell_ctl_t           ctl;
    cell_data_t          cell_q [CAPACITY];
    logic [ID_W-1:0]     cell_ids [CAPACITY];
    logic [CAPACITY-1:0] occ_vec, cand_vec, msb_vec, shift_vec;
    logic [CAPACITY-1:0] pick_sel, pick_shift;
    logic [ID_W-1:0]     pick_id;
    logic                pick_load;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_money = s_tdata[OP_W+VALUE_W-1:OP_W];
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    // row of cells, each fed by its upper neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic       prev_occ;
        cell_data_t upper;
        if (i == 0) begin : g_first
            assign prev_occ = 1'b1;
        end else begin : g_mid
            assign prev_occ = cell_q[i-1].occ;
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper = '0;
        end else begin : g_inner
            assign upper = cell_q[i+1];
        end
        fpds_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .prev_occ (prev_occ),
            .shift_en (shift_vec[i]),
            .upper    (upper),
            .data     (cell_q[i]),
            .cand     (cand_vec[i]),
            .msb      (msb_vec[i])
        );
        assign occ_vec[i]  = cell_q[i].occ;
        assign cell_ids[i] = cell_q[i].id;
    end

    fpds_pick u_pick (
        .aclk      (aclk),
        .load      (pick_load),
        .cand_vec  (cand_vec),
        .ids       (cell_ids),
        .sel       (pick_sel),
        .shift_vec (pick_shift),
        .pick_id   (pick_id)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        bit_cnt_next  = bit_cnt_reg;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        out_set       = 1'b0;
        pick_load     = 1'b0;
        shift_vec     = '0;
        ctl.cmd       = CELL_HOLD;
        ctl.any_hi    = 1'b0;
        ctl.new_id    = next_id_reg;
        ctl.new_value = in_money;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    unique case (in_op)
                        OP_ARRIVE: begin
                            out_set = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                m_status_next = STAT_FULL;
                                m_id_next     = '0;
                            end else begin
                                ctl.cmd       = CELL_APPEND;
                                m_status_next = STAT_STORED;
                                m_id_next     = next_id_reg;
                                next_id_next  = next_id_reg + ID_W'(1);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_OLDEST: begin
                            out_set = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = STAT_EMPTY;
                                m_id_next     = '0;
                            end else begin
                                ctl.cmd       = CELL_REMOVE;
                                shift_vec     = '1;
                                m_status_next = STAT_SERVED;
                                m_id_next     = cell_q[0].id;
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        OP_RICHEST: begin
                            if (count_reg == '0) begin
                                out_set       = 1'b1;
                                m_status_next = STAT_EMPTY;
                                m_id_next     = '0;
                            end else begin
                                ctl.cmd      = CELL_LOAD;
                                bit_cnt_next = '0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default: begin
                            out_set       = 1'b1;
                            m_status_next = STAT_EMPTY;
                            m_id_next     = '0;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // one value bit per cycle, msb first
                ctl.cmd      = CELL_STEP;
                ctl.any_hi   = |(cand_vec & msb_vec);
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(VALUE_W - 1)) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                pick_load  = 1'b1;
                state_next = S_REMOVE;
            end
            S_REMOVE: begin
                ctl.cmd       = CELL_REMOVE;
                shift_vec     = pick_shift;
                out_set       = 1'b1;
                m_status_next = STAT_SERVED;
                m_id_next     = pick_id;
                count_next    = count_reg - CNT_W'(1);
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_set) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            next_id_reg <= ID_W'(1);
            bit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            bit_cnt_reg <= bit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STAT_W - ID_W){1'b0}}, m_id_reg, m_status_reg};

    // fill count matches the occupied cells
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == int'(count_reg))
        else $error("fill count disagrees with occupied cells");

    // fill count never exceeds the row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // the search never loses every candidate
    a_cand_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH || state_reg == S_PICK) |-> (cand_vec != '0))
        else $error("value search lost all candidates");

    // exactly one cell is chosen for removal
    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REMOVE |-> $onehot(pick_sel))
        else $error("pick did not choose exactly one cell");

    // a richest request on a non-empty store starts a search
    a_richest_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_op == OP_RICHEST && count_reg != '0) |=> state_reg == S_SEARCH)
        else $error("richest request did not start a search");

endmodule
